### rtl/su2le_pkg.sv
// ----------------------------------------------------------------------------
// su2le_pkg
// Shared types, fixed-point constants and helpers for the SU(2) link
// exponential update pipeline.
// ----------------------------------------------------------------------------
package su2le_pkg;

  // Default CORDIC depth
  localparam int TRIG_ITER_DEF = 24;

  // Range reduction: quotient of |A| by 2*pi fits in nine bits
  localparam int MOD_STEPS = 9;

  // Quotient bits of the sinc divider
  localparam int DIV_QBITS = 36;

  // Input request: momenta Q8.24, link entries Q2.30
  typedef struct packed {
    logic signed [31:0] mom_x;
    logic signed [31:0] mom_y;
    logic signed [31:0] mom_z;
    logic signed [31:0] link_a_re;
    logic signed [31:0] link_a_im;
    logic signed [31:0] link_b_re;
    logic signed [31:0] link_b_im;
  } in_item_t;

  // Result: updated link entries Q2.30
  typedef struct packed {
    logic signed [31:0] new_a_re;
    logic signed [31:0] new_a_im;
    logic signed [31:0] new_b_re;
    logic signed [31:0] new_b_im;
  } out_item_t;

  // Sideband carried through the divider
  typedef struct packed {
    in_item_t           item;
    logic signed [33:0] cos_v;
    logic [30:0]        sinc_s;
    logic               is_small;
  } div_side_t;

  // Angle constants
  localparam logic [63:0]        TWO_PI_Q52      = 64'h0064_87ED_5110_B461;
  localparam logic signed [34:0] PI_Q30          = 35'sd3373259426;
  localparam logic signed [34:0] HALF_PI_Q30     = 35'sd1686629713;
  localparam logic signed [34:0] TWO_PI_Q30      = 35'sd6746518852;
  localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;
  localparam logic [30:0]        ONE_Q30         = 31'd1073741824;

  // Reciprocals for the small-angle series, exact floor over the value range
  localparam logic [21:0] RECIP6   = 22'd2796203;   // ceil(2^24/6), q < 2^22
  localparam logic [17:0] RECIP120 = 18'd139811;    // ceil(2^24/120), v < 2^14

  // CORDIC arctangent table, Q30
  function automatic logic signed [34:0] atan_entry(input int i);
    logic signed [34:0] v;
    case (i)
      0:  v = 35'sd843314857;
      1:  v = 35'sd497837829;
      2:  v = 35'sd263043837;
      3:  v = 35'sd133525159;
      4:  v = 35'sd67021687;
      5:  v = 35'sd33543516;
      6:  v = 35'sd16775851;
      7:  v = 35'sd8388437;
      8:  v = 35'sd4194283;
      9:  v = 35'sd2097149;
      10: v = 35'sd1048576;
      default: begin
        if (i <= 30) v = 35'sd1 <<< (30 - i);
        else         v = '0;
      end
    endcase
    return v;
  endfunction

  // Saturate to 32 bits signed
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647)       r = 32'sh7FFF_FFFF;
    else if (v < -64'sd2147483648) r = 32'sh8000_0000;
    else                           r = v[31:0];
    return r;
  endfunction

endpackage

### rtl/su2_link_exponential_update.sv
// Throughput: one request per cycle while a stalled output does not hold the
// pipeline; every stage is a register stage. Most of the depth is in
// the 32-stage square root, the 36-stage sinc divider and the CORDIC
// chain; a stalled output freezes the whole pipeline.
// Reset (synchronous, rst_n low) clears all valid bits and step_size to 0.
// ----------------------------------------------------------------------------
// su2_link_exponential_update
// Per-link SU(2) update: exp of the scaled adjoint momentum times the link.
// ----------------------------------------------------------------------------
module su2_link_exponential_update #(
  parameter int TRIG_ITERATIONS = su2le_pkg::TRIG_ITER_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // input requests
  input  logic                 in_valid,
  output logic                 in_stall,
  input  su2le_pkg::in_item_t  in_data,
  // results
  output logic                 out_valid,
  input  logic                 out_stall,
  output su2le_pkg::out_item_t out_data,
  // step size register
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic signed [31:0]   cfg_data
);

  // Pipeline advances when the output register is empty or being taken
  logic adv;
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  // Step size register, Q4.28
  logic signed [31:0] step_size_r;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) step_size_r <= '0;
    else if (cfg_valid && cfg_ready) step_size_r <= cfg_data;
  end

  // Norm
  logic                n_vld;
  logic [31:0]         n_norm;
  su2le_pkg::in_item_t n_item;

  su2le_norm u_norm (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_vld   (in_valid),
    .in_item  (in_data),
    .out_vld  (n_vld),
    .out_norm (n_norm),
    .out_item (n_item)
  );

  // Angle and trig
  logic                 t_vld;
  logic signed [33:0]   t_sin;
  logic [40:0]          t_a30;
  su2le_pkg::div_side_t t_side;

  su2le_trig #(
    .TRIG_ITERATIONS (TRIG_ITERATIONS)
  ) u_trig (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .step_size (step_size_r),
    .in_vld    (n_vld),
    .in_norm   (n_norm),
    .in_item   (n_item),
    .out_vld   (t_vld),
    .out_sin   (t_sin),
    .out_a30   (t_a30),
    .out_side  (t_side)
  );

  // Sinc
  logic                 d_vld;
  logic signed [36:0]   d_sinc;
  su2le_pkg::div_side_t d_side;

  su2le_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_vld   (t_vld),
    .in_sin   (t_sin),
    .in_a30   (t_a30),
    .in_side  (t_side),
    .out_vld  (d_vld),
    .out_sinc (d_sinc),
    .out_side (d_side)
  );

  // Matrix and link product
  su2le_rotate u_rotate (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .step_size (step_size_r),
    .in_vld    (d_vld),
    .in_sinc   (d_sinc),
    .in_side   (d_side),
    .out_vld   (out_valid),
    .out_item  (out_data)
  );

endmodule

### rtl/su2le_norm.sv
// ----------------------------------------------------------------------------
// su2le_norm
// Momentum norm: squares, exact sum, then a 32-stage pipelined integer
// square root resolving one root bit per stage.
// ----------------------------------------------------------------------------
module su2le_norm (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_vld,
  input  su2le_pkg::in_item_t in_item,
  output logic                out_vld,
  output logic [31:0]         out_norm,
  output su2le_pkg::in_item_t out_item
);

  localparam int ROOT_BITS = 32;

  // Stage 1: squares
  logic signed [63:0] sqx_nxt, sqy_nxt, sqz_nxt;
  logic [62:0]        sqx_r, sqy_r, sqz_r;
  logic               s1_vld_r;
  su2le_pkg::in_item_t s1_item_r;

  assign sqx_nxt = in_item.mom_x * in_item.mom_x;
  assign sqy_nxt = in_item.mom_y * in_item.mom_y;
  assign sqz_nxt = in_item.mom_z * in_item.mom_z;

  always_ff @(posedge clk) begin
    if (!rst_n) s1_vld_r <= 1'b0;
    else if (en) s1_vld_r <= in_vld;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sqx_r     <= sqx_nxt[62:0];
      sqy_r     <= sqy_nxt[62:0];
      sqz_r     <= sqz_nxt[62:0];
      s1_item_r <= in_item;
    end
  end

  // Stage 2: exact sum, Q16.48
  logic [63:0]         sum_r;
  logic                s2_vld_r;
  su2le_pkg::in_item_t s2_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s2_vld_r <= 1'b0;
    else if (en) s2_vld_r <= s1_vld_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum_r     <= 64'(sqx_r) + 64'(sqy_r) + 64'(sqz_r);
      s2_item_r <= s1_item_r;
    end
  end

  // Square root stages: two radicand bits in, one root bit out
  logic [33:0]         rem_r  [0:ROOT_BITS-1];
  logic [31:0]         root_r [0:ROOT_BITS-1];
  logic [63:0]         num_r  [0:ROOT_BITS-1];
  logic                vld_r  [0:ROOT_BITS-1];
  su2le_pkg::in_item_t item_r [0:ROOT_BITS-1];

  for (genvar k = 0; k < ROOT_BITS; k++) begin : g_stage
    logic [33:0]         rem_i;
    logic [31:0]         root_i;
    logic [63:0]         num_i;
    logic                vld_i;
    su2le_pkg::in_item_t item_i;
    logic [35:0]         part, trial, diff;
    logic                ge;
    logic [33:0]         rem_nxt;
    logic [31:0]         root_nxt;

    if (k == 0) begin : g_first
      assign rem_i  = '0;
      assign root_i = '0;
      assign num_i  = sum_r;
      assign vld_i  = s2_vld_r;
      assign item_i = s2_item_r;
    end else begin : g_next
      assign rem_i  = rem_r[k-1];
      assign root_i = root_r[k-1];
      assign num_i  = num_r[k-1];
      assign vld_i  = vld_r[k-1];
      assign item_i = item_r[k-1];
    end

    assign part     = {rem_i, num_i[63:62]};
    assign trial    = {2'b00, root_i, 2'b01};
    assign diff     = part - trial;
    assign ge       = (part >= trial);
    assign rem_nxt  = ge ? diff[33:0] : part[33:0];
    assign root_nxt = {root_i[30:0], ge};

    always_ff @(posedge clk) begin
      if (!rst_n) vld_r[k] <= 1'b0;
      else if (en) vld_r[k] <= vld_i;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= rem_nxt;
        root_r[k] <= root_nxt;
        num_r[k]  <= {num_i[61:0], 2'b00};
        item_r[k] <= item_i;
      end
    end
  end

  assign out_vld  = vld_r[ROOT_BITS-1];
  assign out_norm = root_r[ROOT_BITS-1];
  assign out_item = item_r[ROOT_BITS-1];

endmodule

### rtl/su2le_trig.sv
// ----------------------------------------------------------------------------
// su2le_trig
// Angle |d|*n, reduction modulo 2*pi, small-angle sinc series and a
// pipelined rotation-mode CORDIC giving cos and sin.
// ----------------------------------------------------------------------------
module su2le_trig #(
  parameter int TRIG_ITERATIONS = su2le_pkg::TRIG_ITER_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic signed [31:0]   step_size,
  input  logic                 in_vld,
  input  logic [31:0]          in_norm,
  input  su2le_pkg::in_item_t  in_item,
  output logic                 out_vld,
  output logic signed [33:0]   out_sin,
  output logic [40:0]          out_a30,
  output su2le_pkg::div_side_t out_side
);

  localparam int MS = su2le_pkg::MOD_STEPS;
  localparam int NI = TRIG_ITERATIONS;

  typedef struct packed {
    su2le_pkg::in_item_t item;
    logic                neg;
    logic                is_small;
    logic [30:0]         sinc_s;
    logic [40:0]         a30;
  } tside_t;

  // Stage T0: unsigned angle Q12.52
  logic [31:0]         dabs;
  logic [63:0]         aabs_r;
  logic                t0_vld_r;
  su2le_pkg::in_item_t t0_item_r;

  assign dabs = step_size[31] ? 32'(-step_size) : 32'(step_size);

  always_ff @(posedge clk) begin
    if (!rst_n) t0_vld_r <= 1'b0;
    else if (en) t0_vld_r <= in_vld;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      aabs_r    <= dabs * in_norm;
      t0_item_r <= in_item;
    end
  end

  // Range reduction: one conditional subtract of 2*pi << j per stage
  logic [63:0]         mrem_r  [0:MS-1];
  logic [40:0]         ma30_r  [0:MS-1];
  logic                mvld_r  [0:MS-1];
  su2le_pkg::in_item_t mitem_r [0:MS-1];

  for (genvar k = 0; k < MS; k++) begin : g_mod
    localparam logic [63:0] MOD_K = su2le_pkg::TWO_PI_Q52 << (MS - 1 - k);
    logic [63:0]         rem_i;
    logic [40:0]         a30_i;
    logic                vld_i;
    su2le_pkg::in_item_t item_i;
    logic [63:0]         rem_nxt;

    if (k == 0) begin : g_first
      assign rem_i  = aabs_r;
      assign a30_i  = aabs_r[62:22];
      assign vld_i  = t0_vld_r;
      assign item_i = t0_item_r;
    end else begin : g_next
      assign rem_i  = mrem_r[k-1];
      assign a30_i  = ma30_r[k-1];
      assign vld_i  = mvld_r[k-1];
      assign item_i = mitem_r[k-1];
    end

    assign rem_nxt = (rem_i >= MOD_K) ? rem_i - MOD_K : rem_i;

    always_ff @(posedge clk) begin
      if (!rst_n) mvld_r[k] <= 1'b0;
      else if (en) mvld_r[k] <= vld_i;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        mrem_r[k]  <= rem_nxt;
        ma30_r[k]  <= a30_i;
        mitem_r[k] <= item_i;
      end
    end
  end

  // Stage F: fold into [-pi/2, pi/2], square the angle for the series
  logic signed [34:0] z0, z1, z_nxt;
  logic               neg_nxt;
  logic [51:0]        a30_sq;
  logic [40:0]        a30_m;

  assign a30_m  = ma30_r[MS-1];
  assign z0     = {2'b00, mrem_r[MS-1][54:22]};
  assign z1     = (z0 > su2le_pkg::PI_Q30) ? z0 - su2le_pkg::TWO_PI_Q30 : z0;
  assign a30_sq = a30_m[25:0] * a30_m[25:0];

  always_comb begin
    z_nxt   = z1;
    neg_nxt = 1'b0;
    if (z1 > su2le_pkg::HALF_PI_Q30) begin
      z_nxt   = su2le_pkg::PI_Q30 - z1;
      neg_nxt = 1'b1;
    end else if (z1 < -su2le_pkg::HALF_PI_Q30) begin
      z_nxt   = -su2le_pkg::PI_Q30 - z1;
      neg_nxt = 1'b1;
    end
  end

  logic signed [34:0]  f_z_r;
  logic [21:0]         f_q_r;
  logic                f_vld_r;
  tside_t              f_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) f_vld_r <= 1'b0;
    else if (en) f_vld_r <= mvld_r[MS-1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_z_r             <= z_nxt;
      f_q_r             <= a30_sq[51:30];
      f_side_r.item     <= mitem_r[MS-1];
      f_side_r.neg      <= neg_nxt;
      f_side_r.is_small <= (a30_m[40:26] == '0);
      f_side_r.sinc_s   <= '0;
      f_side_r.a30      <= a30_m;
    end
  end

  // Stage G: q/6 and q*q >> 30
  logic [43:0]        q6_prod, qq_prod;
  logic [19:0]        g_q6_r;
  logic [13:0]        g_qq_r;
  logic signed [34:0] g_z_r;
  logic               g_vld_r;
  tside_t             g_side_r;

  assign q6_prod = f_q_r * su2le_pkg::RECIP6;
  assign qq_prod = f_q_r * f_q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) g_vld_r <= 1'b0;
    else if (en) g_vld_r <= f_vld_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g_q6_r   <= q6_prod[43:24];
      g_qq_r   <= qq_prod[43:30];
      g_z_r    <= f_z_r;
      g_side_r <= f_side_r;
    end
  end

  // Stage H: series sinc = 1 - q/6 + q^2/120
  logic [31:0]        q120_prod;
  logic [30:0]        sinc_s_nxt;
  tside_t             h_side_nxt;
  logic signed [34:0] h_z_r;
  logic               h_vld_r;
  tside_t             h_side_r;

  assign q120_prod  = g_qq_r * su2le_pkg::RECIP120;
  assign sinc_s_nxt = su2le_pkg::ONE_Q30 - 31'(g_q6_r) + 31'(q120_prod[31:24]);

  always_comb begin
    h_side_nxt        = g_side_r;
    h_side_nxt.sinc_s = sinc_s_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) h_vld_r <= 1'b0;
    else if (en) h_vld_r <= g_vld_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h_z_r    <= g_z_r;
      h_side_r <= h_side_nxt;
    end
  end

  // CORDIC micro-rotations, one per stage
  logic signed [33:0] cx_r   [0:NI-1];
  logic signed [33:0] cy_r   [0:NI-1];
  logic signed [34:0] cz_r   [0:NI-1];
  logic               cvld_r [0:NI-1];
  tside_t             cside_r[0:NI-1];

  for (genvar i = 0; i < NI; i++) begin : g_cordic
    localparam logic signed [34:0] ATAN_I = su2le_pkg::atan_entry(i);
    logic signed [33:0] x_i, y_i, x_nxt, y_nxt;
    logic signed [34:0] z_i, zn_nxt;
    logic               vld_i;
    tside_t             side_i;

    if (i == 0) begin : g_first
      assign x_i    = su2le_pkg::CORDIC_GAIN_Q30;
      assign y_i    = '0;
      assign z_i    = h_z_r;
      assign vld_i  = h_vld_r;
      assign side_i = h_side_r;
    end else begin : g_next
      assign x_i    = cx_r[i-1];
      assign y_i    = cy_r[i-1];
      assign z_i    = cz_r[i-1];
      assign vld_i  = cvld_r[i-1];
      assign side_i = cside_r[i-1];
    end

    always_comb begin
      if (z_i >= 0) begin
        x_nxt  = x_i - (y_i >>> i);
        y_nxt  = y_i + (x_i >>> i);
        zn_nxt = z_i - ATAN_I;
      end else begin
        x_nxt  = x_i + (y_i >>> i);
        y_nxt  = y_i - (x_i >>> i);
        zn_nxt = z_i + ATAN_I;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) cvld_r[i] <= 1'b0;
      else if (en) cvld_r[i] <= vld_i;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        cx_r[i]    <= x_nxt;
        cy_r[i]    <= y_nxt;
        cz_r[i]    <= zn_nxt;
        cside_r[i] <= side_i;
      end
    end
  end

  // Outputs toward the divider
  assign out_vld           = cvld_r[NI-1];
  assign out_sin           = cy_r[NI-1];
  assign out_a30           = cside_r[NI-1].a30;
  assign out_side.item     = cside_r[NI-1].item;
  assign out_side.cos_v    = cside_r[NI-1].neg ? -cx_r[NI-1] : cx_r[NI-1];
  assign out_side.sinc_s   = cside_r[NI-1].sinc_s;
  assign out_side.is_small = cside_r[NI-1].is_small;

endmodule

### rtl/su2le_div.sv
// ----------------------------------------------------------------------------
// su2le_div
// Large-angle sinc: (sin << 30) / A30 truncated toward zero, one quotient
// bit per stage, then selection against the series value.
// ----------------------------------------------------------------------------
module su2le_div (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_vld,
  input  logic signed [33:0]   in_sin,
  input  logic [40:0]          in_a30,
  input  su2le_pkg::div_side_t in_side,
  output logic                 out_vld,
  output logic signed [36:0]   out_sinc,
  output su2le_pkg::div_side_t out_side
);

  localparam int QB = su2le_pkg::DIV_QBITS;

  // Stage D0: magnitude and initial partial remainder
  logic signed [33:0]   mag_s;
  logic [32:0]          mag;
  logic [41:0]          d0_rem_r;
  logic [QB-1:0]        d0_bits_r;
  logic [40:0]          d0_den_r;
  logic                 d0_neg_r;
  logic                 d0_vld_r;
  su2le_pkg::div_side_t d0_side_r;

  assign mag_s = in_sin[33] ? -in_sin : in_sin;
  assign mag   = mag_s[32:0];

  always_ff @(posedge clk) begin
    if (!rst_n) d0_vld_r <= 1'b0;
    else if (en) d0_vld_r <= in_vld;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d0_rem_r  <= 42'(mag[32:6]);
      d0_bits_r <= {mag[5:0], 30'b0};
      d0_den_r  <= in_a30;
      d0_neg_r  <= in_sin[33];
      d0_side_r <= in_side;
    end
  end

  // Restoring division stages
  logic [41:0]          rem_r  [0:QB-1];
  logic [QB-1:0]        bits_r [0:QB-1];
  logic [QB-1:0]        quo_r  [0:QB-1];
  logic [40:0]          den_r  [0:QB-1];
  logic                 neg_r  [0:QB-1];
  logic                 vld_r  [0:QB-1];
  su2le_pkg::div_side_t side_r [0:QB-1];

  for (genvar k = 0; k < QB; k++) begin : g_step
    logic [41:0]          rem_i;
    logic [QB-1:0]        bits_i, quo_i;
    logic [40:0]          den_i;
    logic                 neg_i, vld_i, ge;
    su2le_pkg::div_side_t side_i;
    logic [42:0]          part, diff;

    if (k == 0) begin : g_first
      assign rem_i  = d0_rem_r;
      assign bits_i = d0_bits_r;
      assign quo_i  = '0;
      assign den_i  = d0_den_r;
      assign neg_i  = d0_neg_r;
      assign vld_i  = d0_vld_r;
      assign side_i = d0_side_r;
    end else begin : g_next
      assign rem_i  = rem_r[k-1];
      assign bits_i = bits_r[k-1];
      assign quo_i  = quo_r[k-1];
      assign den_i  = den_r[k-1];
      assign neg_i  = neg_r[k-1];
      assign vld_i  = vld_r[k-1];
      assign side_i = side_r[k-1];
    end

    assign part = {rem_i, bits_i[QB-1]};
    assign ge   = (part >= 43'(den_i));
    assign diff = part - 43'(den_i);

    always_ff @(posedge clk) begin
      if (!rst_n) vld_r[k] <= 1'b0;
      else if (en) vld_r[k] <= vld_i;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= ge ? diff[41:0] : part[41:0];
        bits_r[k] <= {bits_i[QB-2:0], 1'b0};
        quo_r[k]  <= {quo_i[QB-2:0], ge};
        den_r[k]  <= den_i;
        neg_r[k]  <= neg_i;
        side_r[k] <= side_i;
      end
    end
  end

  // Final stage: sign and choice between series and quotient
  logic signed [36:0] q_s, sinc_nxt;
  logic               out_vld_r;
  logic signed [36:0] out_sinc_r;
  su2le_pkg::div_side_t out_side_r;

  assign q_s      = {1'b0, quo_r[QB-1]};
  assign sinc_nxt = side_r[QB-1].is_small ? 37'(side_r[QB-1].sinc_s)
                  : (neg_r[QB-1] ? -q_s : q_s);

  always_ff @(posedge clk) begin
    if (!rst_n) out_vld_r <= 1'b0;
    else if (en) out_vld_r <= vld_r[QB-1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_sinc_r <= sinc_nxt;
      out_side_r <= side_r[QB-1];
    end
  end

  assign out_vld  = out_vld_r;
  assign out_sinc = out_sinc_r;
  assign out_side = out_side_r;

endmodule

### rtl/su2le_rotate.sv
// ----------------------------------------------------------------------------
// su2le_rotate
// Builds the exponential matrix terms from cos and sinc, then multiplies
// the link by that matrix with saturation. The last stage is the output
// register.
// ----------------------------------------------------------------------------
module su2le_rotate (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic signed [31:0]   step_size,
  input  logic                 in_vld,
  input  logic signed [36:0]   in_sinc,
  input  su2le_pkg::div_side_t in_side,
  output logic                 out_vld,
  output su2le_pkg::out_item_t out_item
);

  // Q30 product of a matrix term and a link part, floor shift
  function automatic logic signed [33:0] mulq(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    logic signed [63:0] p;
    p = a * b;
    return p[63:30];
  endfunction

  // R0: sine factor S = (d * sinc) >> 30
  logic signed [68:0]  ss_prod;
  logic signed [38:0]  sss_r;
  logic signed [33:0]  r0_cos_r;
  logic                r0_vld_r;
  su2le_pkg::in_item_t r0_item_r;

  assign ss_prod = step_size * in_sinc;

  always_ff @(posedge clk) begin
    if (!rst_n) r0_vld_r <= 1'b0;
    else if (en) r0_vld_r <= in_vld;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sss_r     <= ss_prod[68:30];
      r0_cos_r  <= in_side.cos_v;
      r0_item_r <= in_side.item;
    end
  end

  // R1: S times each momentum, >> 22
  logic signed [70:0]  tx_prod, ty_prod, tz_prod;
  logic signed [48:0]  tx_r, ty_r, tz_r;
  logic signed [33:0]  r1_cos_r;
  logic                r1_vld_r;
  su2le_pkg::in_item_t r1_item_r;

  assign tx_prod = sss_r * r0_item_r.mom_x;
  assign ty_prod = sss_r * r0_item_r.mom_y;
  assign tz_prod = sss_r * r0_item_r.mom_z;

  always_ff @(posedge clk) begin
    if (!rst_n) r1_vld_r <= 1'b0;
    else if (en) r1_vld_r <= r0_vld_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tx_r      <= tx_prod[70:22];
      ty_r      <= ty_prod[70:22];
      tz_r      <= tz_prod[70:22];
      r1_cos_r  <= r0_cos_r;
      r1_item_r <= r0_item_r;
    end
  end

  // R2: saturated matrix terms
  logic signed [31:0]  a11r_r, a11i_r, a12r_r, a12i_r;
  logic                r2_vld_r;
  su2le_pkg::in_item_t r2_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) r2_vld_r <= 1'b0;
    else if (en) r2_vld_r <= r1_vld_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a11r_r    <= su2le_pkg::sat32(64'(r1_cos_r));
      a11i_r    <= su2le_pkg::sat32(64'(tz_r));
      a12r_r    <= su2le_pkg::sat32(64'(ty_r));
      a12i_r    <= su2le_pkg::sat32(64'(tx_r));
      r2_item_r <= r1_item_r;
    end
  end

  // R3: sixteen products
  logic signed [31:0] br, bi, cr, ci;
  logic signed [33:0] p_r [0:15];
  logic               r3_vld_r;

  assign br = r2_item_r.link_a_re;
  assign bi = r2_item_r.link_a_im;
  assign cr = r2_item_r.link_b_re;
  assign ci = r2_item_r.link_b_im;

  always_ff @(posedge clk) begin
    if (!rst_n) r3_vld_r <= 1'b0;
    else if (en) r3_vld_r <= r2_vld_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // new_a real
      p_r[0]  <= mulq(a11r_r, br);
      p_r[1]  <= mulq(a11i_r, bi);
      p_r[2]  <= mulq(a12r_r, cr);
      p_r[3]  <= mulq(a12i_r, ci);
      // new_a imaginary
      p_r[4]  <= mulq(a11r_r, bi);
      p_r[5]  <= mulq(a11i_r, br);
      p_r[6]  <= mulq(a12i_r, cr);
      p_r[7]  <= mulq(a12r_r, ci);
      // new_b real
      p_r[8]  <= mulq(a11r_r, cr);
      p_r[9]  <= mulq(a11i_r, ci);
      p_r[10] <= mulq(a12r_r, br);
      p_r[11] <= mulq(a12i_r, bi);
      // new_b imaginary
      p_r[12] <= mulq(a11r_r, ci);
      p_r[13] <= mulq(a11i_r, cr);
      p_r[14] <= mulq(a12i_r, br);
      p_r[15] <= mulq(a12r_r, bi);
    end
  end

  // R4: sums, saturation, output register
  logic signed [35:0]   s0, s1, s2, s3;
  logic                 out_vld_r;
  su2le_pkg::out_item_t out_item_r;

  assign s0 = 36'(p_r[0])  - 36'(p_r[1])  - 36'(p_r[2])  - 36'(p_r[3]);
  assign s1 = 36'(p_r[4])  + 36'(p_r[5])  - 36'(p_r[6])  + 36'(p_r[7]);
  assign s2 = 36'(p_r[8])  - 36'(p_r[9])  + 36'(p_r[10]) + 36'(p_r[11]);
  assign s3 = 36'(p_r[12]) + 36'(p_r[13]) + 36'(p_r[14]) - 36'(p_r[15]);

  always_ff @(posedge clk) begin
    if (!rst_n) out_vld_r <= 1'b0;
    else if (en) out_vld_r <= r3_vld_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_item_r.new_a_re <= su2le_pkg::sat32(64'(s0));
      out_item_r.new_a_im <= su2le_pkg::sat32(64'(s1));
      out_item_r.new_b_re <= su2le_pkg::sat32(64'(s2));
      out_item_r.new_b_im <= su2le_pkg::sat32(64'(s3));
    end
  end

  assign out_vld  = out_vld_r;
  assign out_item = out_item_r;

endmodule

### test/su2_link_exponential_update_chk.sv
// ----------------------------------------------------------------------------
// su2_link_exponential_update_chk
// Watches the request, result and step size channels of the link update
// block, computes the updated link for every accepted request and compares.
// ----------------------------------------------------------------------------
module su2_link_exponential_update_chk (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  su2le_pkg::in_item_t  in_data,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  su2le_pkg::out_item_t out_data,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic signed [31:0]   cfg_data,
  output int                   fail_count,
  output int                   pending
);

  localparam int TRIG_ITERS = 24;
  localparam longint PI30 = 64'sd3373259426;
  localparam longint HPI30 = 64'sd1686629713;
  localparam longint TPI30 = 64'sd6746518852;
  localparam longint GAIN30 = 64'sd652032874;
  localparam longint ONE30 = 64'sd1073741824;
  localparam logic [63:0] TPI52 = 64'h0064_87ED_5110_B461;

  longint signed step_q28;
  su2le_pkg::out_item_t updated_links[$];

  // floor integer square root
  function automatic logic [63:0] isqrt(input logic [63:0] num);
    logic [63:0] res, bit_v;
    res = '0;
    bit_v = 64'd1 << 62;
    while (bit_v > num) bit_v = bit_v >> 2;
    while (bit_v != 0) begin
      if (num >= res + bit_v) begin
        num = num - (res + bit_v);
        res = (res >> 1) + bit_v;
      end else begin
        res = res >> 1;
      end
      bit_v = bit_v >> 2;
    end
    return res;
  endfunction

  function automatic longint signed atan_q30(input int i);
    longint signed tbl[11] = '{843314857, 497837829, 263043837, 133525159,
      67021687, 33543516, 16775851, 8388437, 4194283, 2097149, 1048576};
    if (i <= 10) return tbl[i];
    if (i <= 30) return 64'sd1 <<< (30 - i);
    return 0;
  endfunction

  function automatic longint signed clip32(input longint signed v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic su2le_pkg::out_item_t rotate_link(input su2le_pkg::in_item_t d,
                                                       input longint signed stp);
    longint signed px, py, pz, br, bi, cr, ci, x, y, z, t, cs, sn, sinc, sf, q;
    longint signed a11r, a11i, a12r, a12i;
    logic [63:0] sum, nrm, dabs, aabs, a30;
    bit neg_cos;
    su2le_pkg::out_item_t r;
    px = d.mom_x; py = d.mom_y; pz = d.mom_z;
    br = d.link_a_re; bi = d.link_a_im; cr = d.link_b_re; ci = d.link_b_im;
    sum = px * px + py * py + pz * pz;
    nrm = isqrt(sum);
    dabs = stp < 0 ? -stp : stp;
    aabs = dabs * nrm;
    // fold the reduced angle to [-pi/2, pi/2], then CORDIC
    z = longint'((aabs % TPI52) >> 22);
    x = GAIN30; y = 0; neg_cos = 0;
    if (z > PI30) z = z - TPI30;
    if (z > HPI30) begin
      z = PI30 - z; neg_cos = 1;
    end else if (z < -HPI30) begin
      z = -PI30 - z; neg_cos = 1;
    end
    for (int i = 0; i < TRIG_ITERS && i < 31; i++) begin
      if (z >= 0) begin
        t = x - (y >>> i); y = y + (x >>> i); x = t; z = z - atan_q30(i);
      end else begin
        t = x + (y >>> i); y = y - (x >>> i); x = t; z = z + atan_q30(i);
      end
    end
    cs = neg_cos ? -x : x;
    sn = y;
    // series for small angles, division otherwise
    a30 = aabs >> 22;
    if (a30 < (64'd1 << 26)) begin
      q = longint'((a30 * a30) >> 30);
      sinc = ONE30 - q / 6 + ((q * q) >>> 30) / 120;
    end else begin
      sinc = (sn * ONE30) / longint'(a30);
    end
    sf = (stp * sinc) >>> 30;
    a11r = clip32(cs);
    a11i = clip32((sf * pz) >>> 22);
    a12r = clip32((sf * py) >>> 22);
    a12i = clip32((sf * px) >>> 22);
    r.new_a_re = 32'(clip32(((a11r * br) >>> 30) - ((a11i * bi) >>> 30)
                          - ((a12r * cr) >>> 30) - ((a12i * ci) >>> 30)));
    r.new_a_im = 32'(clip32(((a11r * bi) >>> 30) + ((a11i * br) >>> 30)
                          - ((a12i * cr) >>> 30) + ((a12r * ci) >>> 30)));
    r.new_b_re = 32'(clip32(((a11r * cr) >>> 30) - ((a11i * ci) >>> 30)
                          + ((a12r * br) >>> 30) + ((a12i * bi) >>> 30)));
    r.new_b_im = 32'(clip32(((a11r * ci) >>> 30) + ((a11i * cr) >>> 30)
                          + ((a12i * br) >>> 30) - ((a12r * bi) >>> 30)));
    return r;
  endfunction

  assign pending = updated_links.size();

  // watch all three channels at each edge
  always @(posedge clk) begin
    su2le_pkg::out_item_t exp_v;
    if (!rst_n) begin
      step_q28 <= 0;
      fail_count <= 0;
      updated_links.delete();
    end else begin
      if (cfg_valid && cfg_ready) step_q28 <= longint'(cfg_data);
      if (in_valid && !in_stall) updated_links.push_back(rotate_link(in_data, step_q28));
      if (out_valid && !out_stall) begin
        if (updated_links.size() == 0) begin
          $error("result with no request pending: %h", out_data);
          fail_count <= fail_count + 1;
        end else begin
          exp_v = updated_links.pop_front();
          if (exp_v.new_a_re !== out_data.new_a_re)
            $error("new_a_re exp %0d got %0d", exp_v.new_a_re, out_data.new_a_re);
          if (exp_v.new_a_im !== out_data.new_a_im)
            $error("new_a_im exp %0d got %0d", exp_v.new_a_im, out_data.new_a_im);
          if (exp_v.new_b_re !== out_data.new_b_re)
            $error("new_b_re exp %0d got %0d", exp_v.new_b_re, out_data.new_b_re);
          if (exp_v.new_b_im !== out_data.new_b_im)
            $error("new_b_im exp %0d got %0d", exp_v.new_b_im, out_data.new_b_im);
          if (exp_v !== out_data) fail_count <= fail_count + 1;
        end
      end
    end
  end

endmodule

### test/su2_link_exponential_update_tb.sv
// ----------------------------------------------------------------------------
// su2_link_exponential_update_tb
// Drives directed and random link update requests through several step
// sizes with random idling and one long output hold-off; the checker
// predicts each result and counts mismatches.
// ----------------------------------------------------------------------------
module su2_link_exponential_update_tb;

  localparam int PIPE_CYCLES = 24 + 90;

  logic clk;
  logic rst_n;
  logic in_valid, in_stall, out_valid, out_stall, cfg_valid, cfg_ready;
  su2le_pkg::in_item_t in_data;
  su2le_pkg::out_item_t out_data;
  logic signed [31:0] cfg_data;
  int fail_count, pending;
  bit hold_off, hold_go, calm;

  su2_link_exponential_update uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  su2_link_exponential_update_chk chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  always begin
    clk = 0; #5;
    clk = 1; #5;
  end

  // random 32-bit value leaning to extremes and small magnitudes
  function automatic logic [31:0] pick32();
    case ($urandom_range(0, 7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom_range(0, 255) - 128;
      3, 4: return $signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_link();
    if ($urandom_range(0, 3) == 0) return pick32();
    return $signed($urandom_range(0, 32'h8000_0000)) - 32'sh4000_0000;
  endfunction

  // one request; valid stays high across back-to-back requests
  task automatic push_link(input su2le_pkg::in_item_t d);
    while (!calm && $urandom_range(0, 99) < 27) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_data <= d;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic write_step(input logic signed [31:0] v);
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (PIPE_CYCLES + 5) @(posedge clk);
    cfg_valid <= 1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
  endtask

  function automatic su2le_pkg::in_item_t rand_req();
    su2le_pkg::in_item_t d;
    d.mom_x = pick32(); d.mom_y = pick32(); d.mom_z = pick32();
    d.link_a_re = pick_link(); d.link_a_im = pick_link();
    d.link_b_re = pick_link(); d.link_b_im = pick_link();
    return d;
  endfunction

  // receiver: random stalls, or a long hold-off when asked
  always @(posedge clk) begin
    if (!rst_n) out_stall <= 0;
    else out_stall <= hold_off || (!calm && $urandom_range(0, 99) < 27);
  end

  // long receiver hold-off, counted in cycles once requested
  initial begin
    hold_off = 0;
    wait (hold_go);
    hold_off = 1;
    repeat (PIPE_CYCLES + 60) @(posedge clk);
    hold_off = 0;
  end

  initial begin
    logic signed [31:0] steps[7];
    su2le_pkg::in_item_t d;
    steps = '{32'sh1000_0000, 32'sh7FFF_FFFF, -32'sh8000_0000, 32'sh0000_0001,
              -32'sh0080_0000, 32'sh0040_0000, 32'sh0000_0000};
    rst_n = 0; in_valid = 0; in_data = '0; cfg_valid = 0; cfg_data = 0;
    hold_go = 0; calm = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // directed: zero step at reset, then extremes, zero and tiny angles
    d = '0; d.link_a_re = 32'sh4000_0000;
    push_link(d);
    write_step(32'sh0100_0000);
    push_link(d);
    d = '{32'sh0100_0000, 0, 0, 32'sh4000_0000, 0, 0, 0}; push_link(d);
    d = '{0, 32'sh0000_0001, 0, 32'sh2D41_3CCC, 0, 32'sh2D41_3CCC, 0}; push_link(d);
    d = '{0, 0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
          32'sh7FFF_FFFF, 32'sh7FFF_FFFF};
    push_link(d);
    d = '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
          32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000};
    push_link(d);
    d = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
          32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF};
    push_link(d);
    d = '{32'sh0320_0000, 32'sh0000_0010, -32'sh0100_0000, 32'sh1000_0000,
          -32'sh3000_0000, 32'sh2000_0000, 32'sh0800_0000};
    push_link(d);
    // random phases through all step settings
    foreach (steps[k]) begin
      write_step(steps[k]);
      for (int n = 0; n < 150; n++) begin
        calm = (k == 2 && n >= 30 && n < 90);
        if (k == 4 && n == 40) hold_go = 1;
        push_link(rand_req());
      end
      calm = 0;
    end
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (PIPE_CYCLES + 10) @(posedge clk);
    if (fail_count == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #3000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
